FILE: rtl/pitm_pkg.sv
package pitm_pkg;

    // blend fraction, Q1.16
    localparam int FRAC_W   = 17;
    localparam int FRAC_ONE = 65536;
    localparam int ONE_Q14  = 16384;

    // widths along the datapath
    localparam int COMP_W   = 16;   // packed quaternion component
    localparam int QB_W     = 17;   // blended component, -32768..32768
    localparam int POS_W    = 32;
    localparam int PROD_W   = 34;   // component product
    localparam int NRM_W    = 33;   // sum of four squares
    localparam int MAG_W    = 32;   // numerator magnitude before the Q15 scale
    localparam int REM_W    = 48;   // scaled numerator and running remainder
    localparam int QUO_W    = 16;   // rounded-down quotient, at most 32768

    localparam int NUM_ENT  = 9;
    localparam int NUM_COMP = 4;
    localparam int NUM_AX   = 3;

    // pipeline stage numbers
    localparam int S_DOT    = 0;
    localparam int S_MUL    = 1;
    localparam int S_BLEND  = 2;
    localparam int S_PROD   = 3;
    localparam int S_SUM    = 4;
    localparam int S_DIV0   = 5;
    localparam int DIV_BITS = QUO_W;
    localparam int S_OUT    = S_DIV0 + DIV_BITS;
    localparam int NSTG     = S_OUT + 1;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [QB_W-1:0]   qcomp_t;
    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [REM_W-1:0]         rem_t;
    typedef logic [QUO_W-1:0]         quo_t;
    typedef logic [NRM_W-1:0]         nrm_t;

    // matrix entries that take one minus the ratio
    function automatic logic is_diag(input int e);
        return (e == 0) || (e == 4) || (e == 8);
    endfunction

endpackage

FILE: rtl/pose_interpolate_to_matrix.sv
// channel   | handshake                    | payload
// ----------+------------------------------+---------------------------------------------
// input     | in_valid / in_stall          | prev_pos_*, curr_pos_*, prev/curr_rotation
// output    | out_valid / out_stall        | rot_00 .. rot_22, out_pos_*
// config    | blend_fraction_we            | blend_fraction
//
// one pose per cycle sustained while out_stall stays low
// the 16-step restoring divider works out one quotient bit per stage
// each stage holds while the next one is full and stalled, so bubbles collapse
// rst_n clears the valid bits and the fraction register only
module pose_interpolate_to_matrix (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              blend_fraction_we,
    input  logic [pitm_pkg::FRAC_W-1:0]       blend_fraction,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [31:0]                prev_pos_x,
    input  logic signed [31:0]                prev_pos_y,
    input  logic signed [31:0]                prev_pos_z,
    input  logic signed [31:0]                curr_pos_x,
    input  logic signed [31:0]                curr_pos_y,
    input  logic signed [31:0]                curr_pos_z,
    input  logic [63:0]                       prev_rotation,
    input  logic [63:0]                       curr_rotation,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [15:0]                rot_00,
    output logic signed [15:0]                rot_01,
    output logic signed [15:0]                rot_02,
    output logic signed [15:0]                rot_10,
    output logic signed [15:0]                rot_11,
    output logic signed [15:0]                rot_12,
    output logic signed [15:0]                rot_20,
    output logic signed [15:0]                rot_21,
    output logic signed [15:0]                rot_22,
    output logic signed [31:0]                out_pos_x,
    output logic signed [31:0]                out_pos_y,
    output logic signed [31:0]                out_pos_z
);

    // fraction register, clamped to one on use
    logic [pitm_pkg::FRAC_W-1:0] frac_reg;
    logic signed [pitm_pkg::FRAC_W:0] frac_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frac_reg <= '0;
        else if (blend_fraction_we)
            frac_reg <= blend_fraction;
    end

    assign frac_eff = (frac_reg > pitm_pkg::FRAC_W'(pitm_pkg::FRAC_ONE))
                    ? (pitm_pkg::FRAC_W+1)'(pitm_pkg::FRAC_ONE)
                    : $signed({1'b0, frac_reg});

    // valid bits and per-stage load enables
    logic [pitm_pkg::NSTG-1:0] valid_reg;
    logic [pitm_pkg::NSTG-1:0] ready;

    always_comb
    begin
        ready[pitm_pkg::S_OUT] = !valid_reg[pitm_pkg::S_OUT] || !out_stall;
        for (int k = pitm_pkg::S_OUT - 1; k >= 0; k--)
            ready[k] = !valid_reg[k] || ready[k+1];
    end

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[pitm_pkg::S_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (ready[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < pitm_pkg::NSTG; k++)
                if (ready[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    // stage 0: unpack, dot product sign, position deltas
    pitm_pkg::comp_t   qa_in  [pitm_pkg::NUM_COMP];
    pitm_pkg::comp_t   qb_in  [pitm_pkg::NUM_COMP];
    pitm_pkg::pos_t    pa_in  [pitm_pkg::NUM_AX];
    pitm_pkg::pos_t    pb_in  [pitm_pkg::NUM_AX];
    logic signed [33:0] dot;

    pitm_pkg::comp_t    qa1_reg [pitm_pkg::NUM_COMP];
    pitm_pkg::comp_t    qb1_reg [pitm_pkg::NUM_COMP];
    logic               dneg1_reg;
    pitm_pkg::pos_t     pa1_reg [pitm_pkg::NUM_AX];
    logic signed [32:0] pd1_reg [pitm_pkg::NUM_AX];

    assign pa_in[0] = prev_pos_x;
    assign pa_in[1] = prev_pos_y;
    assign pa_in[2] = prev_pos_z;
    assign pb_in[0] = curr_pos_x;
    assign pb_in[1] = curr_pos_y;
    assign pb_in[2] = curr_pos_z;

    always_comb
    begin
        dot = '0;
        for (int i = 0; i < pitm_pkg::NUM_COMP; i++)
        begin
            qa_in[i] = $signed(prev_rotation[63-16*i -: 16]);
            qb_in[i] = $signed(curr_rotation[63-16*i -: 16]);
            dot      = dot + 34'(qa_in[i] * qb_in[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[pitm_pkg::S_DOT])
        begin
            qa1_reg   <= qa_in;
            qb1_reg   <= qb_in;
            dneg1_reg <= dot[33];
            for (int a = 0; a < pitm_pkg::NUM_AX; a++)
            begin
                pa1_reg[a] <= pa_in[a];
                pd1_reg[a] <= 33'(pb_in[a]) - 33'(pa_in[a]);
            end
        end
    end

    // stage 1: hemisphere flip, delta times fraction
    pitm_pkg::comp_t    qa2_reg    [pitm_pkg::NUM_COMP];
    logic signed [35:0] qprod2_reg [pitm_pkg::NUM_COMP];
    pitm_pkg::pos_t     pa2_reg    [pitm_pkg::NUM_AX];
    logic signed [50:0] pprod2_reg [pitm_pkg::NUM_AX];

    always_ff @(posedge clk)
    begin
        if (ready[pitm_pkg::S_MUL])
        begin
            for (int i = 0; i < pitm_pkg::NUM_COMP; i++)
            begin
                qa2_reg[i]    <= qa1_reg[i];
                qprod2_reg[i] <= 36'((dneg1_reg ? -18'(qb1_reg[i]) : 18'(qb1_reg[i]))
                                     - 18'(qa1_reg[i])) * 36'(frac_eff);
            end
            for (int a = 0; a < pitm_pkg::NUM_AX; a++)
            begin
                pa2_reg[a]    <= pa1_reg[a];
                pprod2_reg[a] <= 51'(pd1_reg[a]) * 51'(frac_eff);
            end
        end
    end

    // stage 2: round, floor shift, add base
    pitm_pkg::qcomp_t q3_reg  [pitm_pkg::NUM_COMP];
    pitm_pkg::pos_t   pos3_reg[pitm_pkg::NUM_AX];

    always_ff @(posedge clk)
    begin
        if (ready[pitm_pkg::S_BLEND])
        begin
            for (int i = 0; i < pitm_pkg::NUM_COMP; i++)
                q3_reg[i] <= 17'(qa2_reg[i]) + 17'((qprod2_reg[i] + 36'sd32768) >>> 16);
            for (int a = 0; a < pitm_pkg::NUM_AX; a++)
                pos3_reg[a] <= pa2_reg[a] + 32'((pprod2_reg[a] + 51'sd32768) >>> 16);
        end
    end

    // stage 3: component products
    pitm_pkg::prod_t ww4_reg, xx4_reg, yy4_reg, zz4_reg;
    pitm_pkg::prod_t xy4_reg, xz4_reg, yz4_reg, wx4_reg, wy4_reg, wz4_reg;
    pitm_pkg::pos_t  pos4_reg[pitm_pkg::NUM_AX];

    always_ff @(posedge clk)
    begin
        if (ready[pitm_pkg::S_PROD])
        begin
            ww4_reg  <= 34'(q3_reg[0] * q3_reg[0]);
            xx4_reg  <= 34'(q3_reg[1] * q3_reg[1]);
            yy4_reg  <= 34'(q3_reg[2] * q3_reg[2]);
            zz4_reg  <= 34'(q3_reg[3] * q3_reg[3]);
            xy4_reg  <= 34'(q3_reg[1] * q3_reg[2]);
            xz4_reg  <= 34'(q3_reg[1] * q3_reg[3]);
            yz4_reg  <= 34'(q3_reg[2] * q3_reg[3]);
            wx4_reg  <= 34'(q3_reg[0] * q3_reg[1]);
            wy4_reg  <= 34'(q3_reg[0] * q3_reg[2]);
            wz4_reg  <= 34'(q3_reg[0] * q3_reg[3]);
            pos4_reg <= pos3_reg;
        end
    end

    // stage 4: norm, numerators split into sign and magnitude
    logic signed [34:0]  num [pitm_pkg::NUM_ENT];
    logic signed [34:0]  nsum;
    pitm_pkg::nrm_t      n5_reg;
    logic                zero5_reg;
    logic [pitm_pkg::NUM_ENT-1:0] neg5_reg;
    logic [pitm_pkg::MAG_W-1:0]   mag5_reg [pitm_pkg::NUM_ENT];
    pitm_pkg::pos_t      pos5_reg[pitm_pkg::NUM_AX];

    always_comb
    begin
        nsum   = 35'(ww4_reg) + 35'(xx4_reg) + 35'(yy4_reg) + 35'(zz4_reg);
        num[0] = 35'(yy4_reg) + 35'(zz4_reg);
        num[1] = 35'(xy4_reg) - 35'(wz4_reg);
        num[2] = 35'(xz4_reg) + 35'(wy4_reg);
        num[3] = 35'(xy4_reg) + 35'(wz4_reg);
        num[4] = 35'(xx4_reg) + 35'(zz4_reg);
        num[5] = 35'(yz4_reg) - 35'(wx4_reg);
        num[6] = 35'(xz4_reg) - 35'(wy4_reg);
        num[7] = 35'(yz4_reg) + 35'(wx4_reg);
        num[8] = 35'(xx4_reg) + 35'(yy4_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ready[pitm_pkg::S_SUM])
        begin
            n5_reg    <= nsum[pitm_pkg::NRM_W-1:0];
            zero5_reg <= (nsum == '0);
            pos5_reg  <= pos4_reg;
            for (int e = 0; e < pitm_pkg::NUM_ENT; e++)
            begin
                neg5_reg[e] <= num[e][34];
                mag5_reg[e] <= num[e][34] ? 32'(-num[e]) : 32'(num[e]);
            end
        end
    end

    // divider: one restoring step per stage, msb of the quotient first
    pitm_pkg::rem_t rem_reg [pitm_pkg::DIV_BITS][pitm_pkg::NUM_ENT];
    pitm_pkg::quo_t quo_reg [pitm_pkg::DIV_BITS][pitm_pkg::NUM_ENT];
    pitm_pkg::nrm_t nd_reg  [pitm_pkg::DIV_BITS];
    logic           zd_reg  [pitm_pkg::DIV_BITS];
    logic [pitm_pkg::NUM_ENT-1:0] negd_reg [pitm_pkg::DIV_BITS];
    pitm_pkg::pos_t posd_reg[pitm_pkg::DIV_BITS][pitm_pkg::NUM_AX];

    for (genvar k = 0; k < pitm_pkg::DIV_BITS; k++)
    begin : g_div
        pitm_pkg::rem_t rem_in [pitm_pkg::NUM_ENT];
        pitm_pkg::quo_t quo_in [pitm_pkg::NUM_ENT];
        pitm_pkg::nrm_t n_in;
        logic           z_in;
        logic [pitm_pkg::NUM_ENT-1:0] neg_in;
        pitm_pkg::pos_t pos_in [pitm_pkg::NUM_AX];
        pitm_pkg::rem_t dsr;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int e = 0; e < pitm_pkg::NUM_ENT; e++)
                begin
                    // scale by 32768
                    rem_in[e] = {1'b0, mag5_reg[e], 15'b0};
                    quo_in[e] = '0;
                end
                n_in   = n5_reg;
                z_in   = zero5_reg;
                neg_in = neg5_reg;
                pos_in = pos5_reg;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                rem_in = rem_reg[k-1];
                quo_in = quo_reg[k-1];
                n_in   = nd_reg[k-1];
                z_in   = zd_reg[k-1];
                neg_in = negd_reg[k-1];
                pos_in = posd_reg[k-1];
            end
        end

        assign dsr = pitm_pkg::rem_t'(n_in) << (pitm_pkg::DIV_BITS - 1 - k);

        always_ff @(posedge clk)
        begin
            if (ready[pitm_pkg::S_DIV0 + k])
            begin
                for (int e = 0; e < pitm_pkg::NUM_ENT; e++)
                begin
                    if (rem_in[e] >= dsr)
                    begin
                        rem_reg[k][e] <= rem_in[e] - dsr;
                        quo_reg[k][e] <= quo_in[e] | (pitm_pkg::quo_t'(1)
                                         << (pitm_pkg::DIV_BITS - 1 - k));
                    end
                    else
                    begin
                        rem_reg[k][e] <= rem_in[e];
                        quo_reg[k][e] <= quo_in[e];
                    end
                end
                nd_reg[k]   <= n_in;
                zd_reg[k]   <= z_in;
                negd_reg[k] <= neg_in;
                posd_reg[k] <= pos_in;
            end
        end
    end

    // output stage: round half away from zero, sign, one minus on the diagonal,
    // saturate, identity for a zero-length blend
    localparam int LAST = pitm_pkg::DIV_BITS - 1;

    logic signed [15:0] rot_next [pitm_pkg::NUM_ENT];
    logic signed [15:0] rot_reg  [pitm_pkg::NUM_ENT];
    pitm_pkg::pos_t     pos_reg  [pitm_pkg::NUM_AX];

    always_comb
    begin
        logic [16:0]        up;
        logic signed [17:0] rs;
        logic signed [18:0] val;
        for (int e = 0; e < pitm_pkg::NUM_ENT; e++)
        begin
            up  = 17'(quo_reg[LAST][e])
                + 17'({rem_reg[LAST][e], 1'b0} >= 49'(nd_reg[LAST]));
            rs  = negd_reg[LAST][e] ? -$signed({1'b0, up}) : $signed({1'b0, up});
            val = pitm_pkg::is_diag(e) ? 19'(pitm_pkg::ONE_Q14) - 19'(rs) : 19'(rs);
            if (zd_reg[LAST])
                rot_next[e] = pitm_pkg::is_diag(e) ? 16'(pitm_pkg::ONE_Q14) : '0;
            else if (val > 19'(pitm_pkg::ONE_Q14))
                rot_next[e] = 16'(pitm_pkg::ONE_Q14);
            else if (val < -19'(pitm_pkg::ONE_Q14))
                rot_next[e] = -16'(pitm_pkg::ONE_Q14);
            else
                rot_next[e] = 16'(val);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[pitm_pkg::S_OUT])
        begin
            rot_reg <= rot_next;
            pos_reg <= posd_reg[LAST];
        end
    end

    assign rot_00    = rot_reg[0];
    assign rot_01    = rot_reg[1];
    assign rot_02    = rot_reg[2];
    assign rot_10    = rot_reg[3];
    assign rot_11    = rot_reg[4];
    assign rot_12    = rot_reg[5];
    assign rot_20    = rot_reg[6];
    assign rot_21    = rot_reg[7];
    assign rot_22    = rot_reg[8];
    assign out_pos_x = pos_reg[0];
    assign out_pos_y = pos_reg[1];
    assign out_pos_z = pos_reg[2];

    // a stall on the input only when the first stage is holding a request
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> valid_reg[0])
        else $error("input stalled with first stage empty");

    // the divider remainder of entries 0 and 4 ends below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[pitm_pkg::S_OUT - 1] && !zd_reg[LAST])
        |-> (rem_reg[LAST][0] < 48'(nd_reg[LAST]))
         && (rem_reg[LAST][4] < 48'(nd_reg[LAST])))
        else $error("divider remainder out of range");

    // diagonal stays inside the Q2.14 unit range
    a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rot_00 <= 16'sd16384) && (rot_00 >= -16'sd16384)
                   && (rot_11 <= 16'sd16384) && (rot_11 >= -16'sd16384)
                   && (rot_22 <= 16'sd16384) && (rot_22 >= -16'sd16384))
        else $error("matrix entry out of range");

endmodule

FILE: test/pose_interpolate_to_matrix_tb.sv
// pose blend scoreboard: predicts blended matrix and position per request
class pose_blend_board;
    typedef struct {
        logic signed [15:0] rot [9];
        logic signed [31:0] pos [3];
    } pose_result_t;

    pose_result_t pending[$];
    int unsigned  fail_count;
    int unsigned  checked;
    logic [16:0]  fraction;

    function new();
        fail_count = 0;
        checked = 0;
        fraction = '0;
    endfunction

    function void report(string what);
        $display("mismatch: %s", what);
        fail_count++;
    endfunction

    // floor((b - a) * f + half) / 2^16 added to a
    static function longint mix(longint a, longint b, longint f);
        longint v;
        v = (b - a) * f + 32768;
        return a + (v >>> 16);
    endfunction

    static function longint rounded_ratio(longint num, longint n);
        longint u;
        longint q;
        u = (num < 0) ? -num : num;
        q = (2 * u + n) / (2 * n);
        return (num < 0) ? -q : q;
    endfunction

    static function logic signed [15:0] clip(longint v);
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    function void note_request(logic signed [31:0] pp [3], logic signed [31:0] cp [3],
                               logic [63:0] pr, logic [63:0] cr);
        pose_result_t r;
        longint f, dot, n, w, x, y, z;
        longint qa [4];
        longint qb [4];
        longint q [4];
        longint m [9];
        f = (fraction > 17'd65536) ? 65536 : longint'(fraction);
        dot = 0;
        for (int i = 0; i < 4; i++) begin
            qa[i] = longint'($signed(pr[63-16*i -: 16]));
            qb[i] = longint'($signed(cr[63-16*i -: 16]));
            dot += qa[i] * qb[i];
        end
        for (int i = 0; i < 4; i++) begin
            if (dot < 0) qb[i] = -qb[i];
            q[i] = mix(qa[i], qb[i], f);
        end
        w = q[0]; x = q[1]; y = q[2]; z = q[3];
        n = w*w + x*x + y*y + z*z;
        if (n == 0) begin
            for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 16384 : 0;
        end
        else begin
            m[0] = 16384 - rounded_ratio(32768 * (y*y + z*z), n);
            m[1] = rounded_ratio(32768 * (x*y - w*z), n);
            m[2] = rounded_ratio(32768 * (x*z + w*y), n);
            m[3] = rounded_ratio(32768 * (x*y + w*z), n);
            m[4] = 16384 - rounded_ratio(32768 * (x*x + z*z), n);
            m[5] = rounded_ratio(32768 * (y*z - w*x), n);
            m[6] = rounded_ratio(32768 * (x*z - w*y), n);
            m[7] = rounded_ratio(32768 * (y*z + w*x), n);
            m[8] = 16384 - rounded_ratio(32768 * (x*x + y*y), n);
        end
        for (int i = 0; i < 9; i++) r.rot[i] = clip(m[i]);
        for (int i = 0; i < 3; i++) begin
            longint p;
            p = mix(longint'(pp[i]), longint'(cp[i]), f);
            r.pos[i] = p[31:0];
        end
        pending = {pending, r};
    endfunction

    function void check_result(logic signed [15:0] rot [9], logic signed [31:0] pos [3]);
        pose_result_t e;
        checked++;
        if (pending.size() == 0) begin
            report("result with no request waiting");
            return;
        end
        e = pending.pop_front();
        for (int i = 0; i < 9; i++)
            if (rot[i] !== e.rot[i])
                report($sformatf("rot entry %0d got %0d want %0d", i, rot[i], e.rot[i]));
        for (int i = 0; i < 3; i++)
            if (pos[i] !== e.pos[i])
                report($sformatf("pos axis %0d got %0d want %0d", i, pos[i], e.pos[i]));
    endfunction
endclass

module pose_interpolate_to_matrix_tb;

    localparam int LATENCY     = 22;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQS = 900;

    logic clk;
    logic rst_n;
    logic blend_fraction_we;
    logic [pitm_pkg::FRAC_W-1:0] blend_fraction;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] prev_pos_x, prev_pos_y, prev_pos_z;
    logic signed [31:0] curr_pos_x, curr_pos_y, curr_pos_z;
    logic [63:0] prev_rotation, curr_rotation;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22;
    logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;

    pose_blend_board board;
    int unsigned cycle_count = 0;
    int unsigned requests_sent;
    // receiver behavior: 0 calm, 1 random stalls, 2 long hold-off
    int drain_mode;
    int hold_cycles;

    pose_interpolate_to_matrix uut (
        .clk(clk), .rst_n(rst_n),
        .blend_fraction_we(blend_fraction_we), .blend_fraction(blend_fraction),
        .in_valid(in_valid), .in_stall(in_stall),
        .prev_pos_x(prev_pos_x), .prev_pos_y(prev_pos_y), .prev_pos_z(prev_pos_z),
        .curr_pos_x(curr_pos_x), .curr_pos_y(curr_pos_y), .curr_pos_z(curr_pos_z),
        .prev_rotation(prev_rotation), .curr_rotation(curr_rotation),
        .out_valid(out_valid), .out_stall(out_stall),
        .rot_00(rot_00), .rot_01(rot_01), .rot_02(rot_02),
        .rot_10(rot_10), .rot_11(rot_11), .rot_12(rot_12),
        .rot_20(rot_20), .rot_21(rot_21), .rot_22(rot_22),
        .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog on total cycles
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // note each request as it is accepted; sampled values are pre-edge
    always @(posedge clk) begin
        logic signed [31:0] pp [3];
        logic signed [31:0] cp [3];
        if (rst_n && in_valid && !in_stall) begin
            pp[0] = prev_pos_x; pp[1] = prev_pos_y; pp[2] = prev_pos_z;
            cp[0] = curr_pos_x; cp[1] = curr_pos_y; cp[2] = curr_pos_z;
            board.note_request(pp, cp, prev_rotation, curr_rotation);
        end
    end

    // check each accepted result
    always @(posedge clk) begin
        logic signed [15:0] rot [9];
        logic signed [31:0] pos [3];
        if (rst_n && out_valid && !out_stall) begin
            rot[0] = rot_00; rot[1] = rot_01; rot[2] = rot_02;
            rot[3] = rot_10; rot[4] = rot_11; rot[5] = rot_12;
            rot[6] = rot_20; rot[7] = rot_21; rot[8] = rot_22;
            pos[0] = out_pos_x; pos[1] = out_pos_y; pos[2] = out_pos_z;
            board.check_result(rot, pos);
        end
    end

    // receiver: stall pattern depends on the phase the stimulus selects
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_cycles <= 0;
        end
        else if (drain_mode == 2) begin
            // long hold-off so the pipeline fills and pushes back on input
            if (hold_cycles < 120) begin
                out_stall <= 1'b1;
                hold_cycles <= hold_cycles + 1;
            end
            else out_stall <= 1'b0;
        end
        else if (drain_mode == 1)
            out_stall <= ($urandom_range(99) < 31);
        else
            out_stall <= 1'b0;
    end

    // random signed Q2.14 component with extremes mixed in
    function automatic logic [15:0] pick_comp();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h4000;
            3: return 16'hc000;
            4: return 16'h0000;
            default: return 16'($urandom_range(32767) - 16384);
        endcase
    endfunction

    function automatic logic [63:0] unitish_quat();
        logic [63:0] q;
        q = {pick_comp(), pick_comp(), pick_comp(), pick_comp()};
        // occasionally full random bits so every bit toggles
        if ($urandom_range(9) == 0) q = {$urandom, $urandom};
        return q;
    endfunction

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_pose(logic [31:0] px, py, pz, cx, cy, cz,
                             logic [63:0] pr, logic [63:0] cr, bit allow_gaps);
        while (allow_gaps && $urandom_range(99) < 31) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        prev_pos_x <= px; prev_pos_y <= py; prev_pos_z <= pz;
        curr_pos_x <= cx; curr_pos_y <= cy; curr_pos_z <= cz;
        prev_rotation <= pr; curr_rotation <= cr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_random(bit allow_gaps);
        logic [63:0] pr;
        logic [63:0] cr;
        pr = unitish_quat();
        cr = unitish_quat();
        if ($urandom_range(3) == 0) cr = pr;
        send_pose(pick_pos(), pick_pos(), pick_pos(), pick_pos(), pick_pos(), pick_pos(),
                  pr, cr, allow_gaps);
    endtask

    // drain everything, then let the pipe empty before a register write
    task automatic settle_and_set(logic [16:0] f);
        in_valid <= 1'b0;
        // let the last accepted request reach the board
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        blend_fraction_we <= 1'b1;
        blend_fraction <= f;
        @(posedge clk);
        blend_fraction_we <= 1'b0;
        board.fraction = f;
    endtask

    initial begin
        logic [16:0] settings [7];
        board = new();
        requests_sent = 0;
        drain_mode = 0;
        rst_n = 1'b0;
        blend_fraction_we = 1'b0;
        blend_fraction = '0;
        in_valid = 1'b0;
        prev_pos_x = '0; prev_pos_y = '0; prev_pos_z = '0;
        curr_pos_x = '0; curr_pos_y = '0; curr_pos_z = '0;
        prev_rotation = '0; curr_rotation = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset fraction of zero, then extremes
        send_pose(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, 1,
                  64'h4000_0000_0000_0000, 64'h0000_4000_0000_0000, 1'b0);
        settle_and_set(17'd65536);
        // positions at opposite extremes, full fraction
        send_pose(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0,
                  64'h4000_0000_0000_0000, 64'h0000_0000_0000_4000, 1'b0);
        // negative dot product: current gets negated
        send_pose(0, 0, 0, 65536, 65536, 65536,
                  64'h4000_0000_0000_0000, 64'hc000_0000_0000_0000, 1'b0);
        // dot exactly zero: no negation
        send_pose(1, 2, 3, 4, 5, 6, 64'h4000_0000_0000_0000, 64'h0000_4000_0000_0000, 1'b0);
        // zero quaternions: identity
        send_pose(0, 0, 0, 0, 0, 0, 64'h0, 64'h0, 1'b0);
        settle_and_set(17'd32768);
        // opposite halves blending to zero length is caught by negation; zero pair
        send_pose(5, 5, 5, -5, -5, -5, 64'h0, 64'h0, 1'b0);
        // non-unit and extreme components
        send_pose(0, 0, 0, 0, 0, 0, 64'h8000_8000_8000_8000, 64'h7fff_7fff_7fff_7fff, 1'b0);
        send_pose(0, 0, 0, 0, 0, 0, 64'h7fff_7fff_7fff_7fff, 64'h7fff_7fff_7fff_7fff, 1'b0);
        send_pose(0, 0, 0, 0, 0, 0, 64'h0001_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b0);
        send_pose(32'hffff_ffff, 0, 0, 0, 32'hffff_ffff, 0,
                  64'hffff_ffff_ffff_ffff, 64'h0000_0000_0000_0000, 1'b0);
        // fraction above one clamps to one
        settle_and_set(17'h1ffff);
        send_pose(0, 100, 200, 65536, 0, 32'h8000_0000,
                  64'h2d41_2d41_0000_0000, 64'h2d41_0000_2d41_0000, 1'b0);
        send_pose(0, 0, 0, 0, 0, 0, 64'h0000_0000_4000_0000, 64'h0000_c000_0000_0000, 1'b0);
        settle_and_set(17'd1);
        send_pose(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_8000,
                  64'h4000_0000_0000_0000, 64'h0000_0000_4000_0000, 1'b0);

        // random phases across several fractions
        settings[0] = 17'd0;
        settings[1] = 17'd65535;
        settings[2] = 17'd65536;
        settings[3] = 17'd65537;
        settings[4] = 17'd16384;
        settings[5] = 17'h1ffff;
        settings[6] = 17'd32768;
        for (int ph = 0; ph < 7; ph++) begin
            settle_and_set(ph == 6 ? 17'($urandom_range(65536)) : settings[ph]);
            if (ph == 2) begin
                // back-to-back stretch with no idling on either side
                drain_mode = 0;
                for (int i = 0; i < RANDOM_REQS / 7; i++) send_random(1'b0);
            end
            else if (ph == 4) begin
                // receiver holds off while requests keep coming
                drain_mode = 2;
                for (int i = 0; i < RANDOM_REQS / 7; i++) send_random(1'b0);
                drain_mode = 1;
            end
            else begin
                drain_mode = 1;
                for (int i = 0; i < RANDOM_REQS / 7; i++) send_random(1'b1);
            end
        end
        in_valid <= 1'b0;
        drain_mode = 0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (board.checked != requests_sent)
            board.report($sformatf("%0d requests sent but %0d results seen",
                                   requests_sent, board.checked));

        $display("covered %0d pose requests, %0d results checked, seven fraction settings",
                 requests_sent, board.checked);
        $display("included negated and zero-length blends, clamped fraction, output hold-off");
        if (board.fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: sim.f
rtl/pitm_pkg.sv
rtl/pose_interpolate_to_matrix.sv
test/pose_interpolate_to_matrix_tb.sv
